### rtl/url_percent_decoder_assert.svh
// Assertion helpers used by the decoder's output buffer.
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define URLPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("urlpd assertion failed");

// Condition must never be true outside reset.
`define URLPD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("urlpd forbidden condition seen");

`endif

### rtl/urlpd_pkg.sv
`default_nettype none
package urlpd_pkg;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

    localparam int         COUNT_BITS_DEF = 8;
    localparam logic [7:0] MAX_BYTES_RST  = 8'd32;

    // One output beat.
    typedef struct packed {
        logic [7:0] data;
        logic       data_valid;
        logic       eos;
    } t_beat;

    // Beats produced by one input item, in order.
    typedef struct packed {
        logic [1:0] n;
        t_beat      b0;
        t_beat      b1;
    } t_dec_res;

    // Outcome of plain (non-escape) handling of one character.
    typedef struct packed {
        logic       emit;
        logic [7:0] ch;
        logic       pend;
    } t_slot;

    // {is_hex, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = c - CHAR_UA + HEX_ALPHA_OFS;
            return {1'b1, d[3:0]};
        end
        if (c >= CHAR_LA && c <= CHAR_LF) begin
            d = c - CHAR_LA + HEX_ALPHA_OFS;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic t_slot idle_feed(input logic [7:0] c, input logic last);
        t_slot s;
        s.emit = 1'b0;
        s.ch   = c;
        s.pend = 1'b0;
        if (c == CHAR_PLUS) begin
            s.emit = 1'b1;
            s.ch   = CHAR_SPACE;
        end else if (c == CHAR_PCT) begin
            if (last) begin
                s.emit = 1'b1;
            end else begin
                s.pend = 1'b1;
            end
        end else begin
            s.emit = 1'b1;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/urlpd_decode.sv
`default_nettype none
module urlpd_decode #(
    parameter int COUNT_BITS = urlpd_pkg::COUNT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [7:0]          i_byte,
    input  wire logic                i_last,
    input  wire logic                i_consume,
    input  wire logic [7:0]          i_limit,
    output urlpd_pkg::t_dec_res      o_res
);

    localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  r_pp, n_pp;
    logic                  r_hv, n_hv;
    logic [7:0]            r_hc, n_hc;
    logic [COUNT_BITS-1:0] r_wc, n_wc;

    urlpd_pkg::t_slot s0, s1, f, g;
    logic [4:0]       hx_hi, hx_lo;
    logic             ok0, ok1;
    logic [COUNT_BITS-1:0] wc1;
    logic [1:0]       k;

    // Candidate characters and next escape state
    always_comb begin
        s0 = '0;
        s1 = '0;
        n_pp = r_pp;
        n_hv = r_hv;
        n_hc = r_hc;
        hx_hi = urlpd_pkg::hex_val(r_hc);
        hx_lo = urlpd_pkg::hex_val(i_byte);
        f = urlpd_pkg::idle_feed(i_byte, i_last);
        g = urlpd_pkg::idle_feed(r_hc, 1'b0);
        if (!r_pp) begin
            s0   = f;
            n_pp = f.pend;
        end else if (!r_hv) begin
            if (i_last) begin
                s0.emit = 1'b1;
                s0.ch   = urlpd_pkg::CHAR_PCT;
                s1      = f;
                n_pp    = 1'b0;
            end else begin
                n_hc = i_byte;
                n_hv = 1'b1;
            end
        end else begin
            n_pp = 1'b0;
            n_hv = 1'b0;
            n_hc = 8'd0;
            if (hx_hi[4] && hx_lo[4]) begin
                s0.emit = 1'b1;
                s0.ch   = {hx_hi[3:0], hx_lo[3:0]};
            end else if (g.pend) begin
                // held '%' reopens an escape with the current byte
                if (i_last) begin
                    s0.emit = 1'b1;
                    s0.ch   = urlpd_pkg::CHAR_PCT;
                    s1      = f;
                end else begin
                    n_pp = 1'b1;
                    n_hv = 1'b1;
                    n_hc = i_byte;
                end
            end else begin
                s0   = g;
                s1   = f;
                n_pp = f.pend;
            end
        end
        if (i_last) begin
            n_pp = 1'b0;
            n_hv = 1'b0;
            n_hc = 8'd0;
        end
    end

    // Output limit gating; a second candidate only exists with a first one
    always_comb begin
        ok0 = s0.emit && (CW'(r_wc) < CW'(i_limit)) && (r_wc != COUNT_MAX);
        wc1 = r_wc + COUNT_BITS'(ok0);
        ok1 = ok0 && s1.emit && (CW'(wc1) < CW'(i_limit)) && (wc1 != COUNT_MAX);
        k   = {1'b0, ok0} + {1'b0, ok1};

        o_res.b0.data       = s0.ch;
        o_res.b0.data_valid = 1'b1;
        o_res.b0.eos        = i_last && !ok1;
        o_res.b1.data       = s1.ch;
        o_res.b1.data_valid = 1'b1;
        o_res.b1.eos        = i_last;
        o_res.n             = k;
        if (!ok0 && i_last) begin
            o_res.b0.data       = 8'd0;
            o_res.b0.data_valid = 1'b0;
            o_res.b0.eos        = 1'b1;
            o_res.n             = 2'd1;
        end
        n_wc = i_last ? '0 : (r_wc + COUNT_BITS'(k));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp <= 1'b0;
            r_hv <= 1'b0;
            r_wc <= '0;
        end else if (i_consume) begin
            r_pp <= n_pp;
            r_hv <= n_hv;
            r_wc <= n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_consume) begin
            r_hc <= n_hc;
        end
    end

endmodule
`default_nettype wire

### rtl/urlpd_out_buf.sv
`default_nettype none
`include "url_percent_decoder_assert.svh"
module urlpd_out_buf (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  urlpd_pkg::t_dec_res      i_res,
    output logic                     o_can_take,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output urlpd_pkg::t_beat         o_beat
);

    logic [1:0]        r_cnt, n_cnt;
    urlpd_pkg::t_beat  r_b0, n_b0;
    urlpd_pkg::t_beat  r_b1, n_b1;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_beat     = r_b0;
    // room for a whole item once the last held beat leaves this cycle
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt = r_cnt;
        n_b0  = r_b0;
        n_b1  = r_b1;
        if (i_load) begin
            n_cnt = i_res.n;
            n_b0  = i_res.b0;
            n_b1  = i_res.b1;
        end else if (o_valid && i_ready) begin
            n_cnt = r_cnt - 2'd1;
            n_b0  = r_b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0 <= n_b0;
        r_b1 <= n_b1;
    end

    `URLPD_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3)
    `URLPD_ASSERT(a_load_room, i_clk, i_rst_n, i_load |-> (o_can_take && i_res.n != 2'd0))
    `URLPD_ASSERT(a_full_hold, i_clk, i_rst_n, (r_cnt == 2'd2 && !i_ready) |=> r_cnt == 2'd2)
    `URLPD_ASSERT(a_full_drain, i_clk, i_rst_n, (r_cnt == 2'd2 && i_ready) |=> r_cnt == 2'd1)

endmodule
`default_nettype wire

### rtl/url_percent_decoder.sv
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+------------------------------------------
// input    | i_in_valid   | o_in_ready   | i_in_byte, i_last_byte
// output   | o_out_valid  | i_out_ready  | o_out_byte, o_byte_valid, o_end_of_string
// config   | i_cfg_valid  | o_cfg_ready  | i_cfg_data (max_output_bytes)
//
// One input beat per cycle when each gives at most one output beat and the output
// is not stalled; an input that yields two output beats waits in the input register
// until the single-beat output port has drained the two-entry result buffer to one beat.
// An item passes the input register, then the result buffer, before its first beat.
// Synchronous active-low reset clears escape state, counters and buffer valids;
// the output limit returns to 32. Config is always ready.
`default_nettype none
module url_percent_decoder #(
    parameter int COUNT_BITS = urlpd_pkg::COUNT_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_byte_valid,
    output logic            o_end_of_string,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic [7:0] r_max;

    urlpd_pkg::t_dec_res res;
    urlpd_pkg::t_beat    beat;
    logic                can_take;
    logic                consume;
    logic                load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= urlpd_pkg::MAX_BYTES_RST;
        end else if (i_cfg_valid) begin
            r_max <= i_cfg_data;
        end
    end

    // items yielding no beat retire without touching the buffer
    assign consume    = r_in_valid && (res.n == 2'd0 || can_take);
    assign load       = consume && (res.n != 2'd0);
    assign o_in_ready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_last_byte;
        end
    end

    urlpd_decode #(
        .COUNT_BITS(COUNT_BITS)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_consume (consume),
        .i_limit   (r_max),
        .o_res     (res)
    );

    urlpd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_res      (res),
        .o_can_take (can_take),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_beat     (beat)
    );

    assign o_out_byte      = beat.data;
    assign o_byte_valid    = beat.data_valid;
    assign o_end_of_string = beat.eos;

endmodule
`default_nettype wire

### tb/url_percent_decoder_checker.sv
`timescale 1ns / 1ps
module url_percent_decoder_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_out_byte,
    input  wire logic       i_byte_valid,
    input  wire logic       i_end_of_string,
    input  wire logic       i_cfg_valid,
    input  wire logic       i_cfg_ready,
    input  wire logic [7:0] i_cfg_data,
    output int              o_err_cnt,
    output int              o_pending
);
    import urlpd_pkg::*;

    localparam int CNT_W     = COUNT_BITS_DEF;
    localparam int CNT_LIMIT = (1 << CNT_W) - 1;

    logic             pct_pend;
    logic             held_vld;
    logic [7:0]       held_ch;
    logic [CNT_W-1:0] wr_cnt;
    logic [7:0]       max_bytes;

    t_beat decoded_q[$];

    // -1 when c is not a hex digit
    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
        if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + int'(HEX_ALPHA_OFS);
        if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + int'(HEX_ALPHA_OFS);
        return -1;
    endfunction

    task automatic push_decoded(input logic [7:0] ch);
        t_beat b;
        if (wr_cnt < max_bytes && int'(wr_cnt) < CNT_LIMIT) begin
            wr_cnt = wr_cnt + 1'b1;
            b.data       = ch;
            b.data_valid = 1'b1;
            b.eos        = 1'b0;
            decoded_q.push_back(b);
        end
    endtask

    task automatic plain_char(input logic [7:0] c, input logic last);
        if (c == CHAR_PLUS) begin
            push_decoded(CHAR_SPACE);
        end else if (c == CHAR_PCT) begin
            if (last) begin
                push_decoded(CHAR_PCT);
            end else begin
                pct_pend = 1'b1;
            end
        end else begin
            push_decoded(c);
        end
    endtask

    // first byte after a '%'
    task automatic after_pct(input logic [7:0] c, input logic last);
        if (last) begin
            pct_pend = 1'b0;
            push_decoded(CHAR_PCT);
            plain_char(c, 1'b1);
        end else begin
            held_ch  = c;
            held_vld = 1'b1;
        end
    endtask

    task automatic decode_item(input logic [7:0] c, input logic last);
        int         n0;
        int         hi;
        int         lo;
        logic [7:0] hc;
        t_beat      b;
        n0 = decoded_q.size();
        if (!pct_pend) begin
            plain_char(c, last);
        end else if (!held_vld) begin
            after_pct(c, last);
        end else begin
            hc       = held_ch;
            hi       = hex_nibble(hc);
            lo       = hex_nibble(c);
            pct_pend = 1'b0;
            held_vld = 1'b0;
            held_ch  = 8'h00;
            if (hi >= 0 && lo >= 0) begin
                push_decoded({hi[3:0], lo[3:0]});
            end else begin
                // bad escape: drop '%', replay both bytes
                plain_char(hc, 1'b0);
                if (pct_pend) begin
                    after_pct(c, last);
                end else begin
                    plain_char(c, last);
                end
            end
        end
        if (last) begin
            if (decoded_q.size() == n0) begin
                b.data       = 8'h00;
                b.data_valid = 1'b0;
                b.eos        = 1'b1;
                decoded_q.push_back(b);
            end else begin
                b     = decoded_q.pop_back();
                b.eos = 1'b1;
                decoded_q.push_back(b);
            end
            pct_pend = 1'b0;
            held_vld = 1'b0;
            held_ch  = 8'h00;
            wr_cnt   = '0;
        end
    endtask

    initial begin
        o_err_cnt = 0;
        o_pending = 0;
        pct_pend  = 1'b0;
        held_vld  = 1'b0;
        held_ch   = 8'h00;
        wr_cnt    = '0;
        max_bytes = MAX_BYTES_RST;
    end

    always @(posedge i_clk) begin
        t_beat want;
        if (!i_rst_n) begin
            pct_pend  = 1'b0;
            held_vld  = 1'b0;
            held_ch   = 8'h00;
            wr_cnt    = '0;
            max_bytes = MAX_BYTES_RST;
            decoded_q.delete();
        end else begin
            // output beat can never stem from an input taken at this same edge
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    o_err_cnt = o_err_cnt + 1;
                    if (o_err_cnt <= 10)
                        $display("%0t: unexpected beat byte=%02h bv=%b eos=%b",
                                 $realtime, i_out_byte, i_byte_valid, i_end_of_string);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_byte !== want.data || i_byte_valid !== want.data_valid ||
                        i_end_of_string !== want.eos) begin
                        o_err_cnt = o_err_cnt + 1;
                        if (o_err_cnt <= 10)
                            $display("%0t: mismatch exp %02h bv=%b eos=%b got %02h bv=%b eos=%b",
                                     $realtime, want.data, want.data_valid, want.eos,
                                     i_out_byte, i_byte_valid, i_end_of_string);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                max_bytes = i_cfg_data;
            if (i_in_valid && i_in_ready)
                decode_item(i_in_byte, i_last_byte);
        end
        o_pending = decoded_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import urlpd_pkg::*;

    localparam int  NUM_PHASES   = 8;
    localparam int  PHASE_ITEMS  = 215;
    localparam int  HOLD_CYCLES  = 300;
    localparam int  SETTLE_CYC   = 10;
    localparam real LIMIT_NS     = 6_000_000.0;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_end_of_string;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    int err_cnt;
    int pending;

    int snd_idle_pct;
    int rcv_stall_pct;
    bit hold_req;
    int phase_items;

    logic [7:0] str_q[$];

    url_percent_decoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_end_of_string (o_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    url_percent_decoder_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .i_last_byte     (i_last_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_out_byte      (o_out_byte),
        .i_byte_valid    (o_byte_valid),
        .i_end_of_string (o_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_err_cnt       (err_cnt),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off when requested
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(15));
        if (v < HEX_ALPHA_OFS) return CHAR_ZERO + v;
        if ($urandom_range(1)) return CHAR_UA + v - HEX_ALPHA_OFS;
        return CHAR_LA + v - HEX_ALPHA_OFS;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            while ($urandom_range(99) < snd_idle_pct) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_byte   <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        phase_items++;
    endtask

    task automatic send_string();
        int k;
        for (k = 0; k < str_q.size(); k++)
            send_byte(str_q[k], k == str_q.size() - 1);
    endtask

    task automatic build_random_string(input int max_tokens);
        int n;
        int k;
        int sel;
        str_q.delete();
        n = $urandom_range(max_tokens, 1);
        for (k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
                str_q.push_back(8'($urandom_range(255)));
            end else if (sel < 40) begin
                str_q.push_back(CHAR_PLUS);
            end else if (sel < 70) begin
                str_q.push_back(CHAR_PCT);
                str_q.push_back(hex_char());
                str_q.push_back(hex_char());
            end else if (sel < 85) begin
                str_q.push_back(CHAR_PCT);
                str_q.push_back(8'($urandom_range(255)));
                str_q.push_back(8'($urandom_range(255)));
            end else if (sel < 95) begin
                str_q.push_back(CHAR_PCT);
            end else begin
                str_q.push_back(hex_char());
            end
        end
    endtask

    // nothing goes in until every predicted beat is out, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stim
        int p;
        int k;
        bit hold_fired;
        logic [7:0] limit_val;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_byte     = 8'h00;
        i_last_byte   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = 8'h00;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req      = 1'b0;
        phase_items   = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed strings, reset limit
        str_q = '{8'h00, 8'hFF};
        send_string();
        str_q = '{CHAR_PLUS};
        send_string();
        str_q = '{CHAR_PCT, CHAR_ZERO + 8'd4, CHAR_ZERO + 8'd1,
                  CHAR_PCT, CHAR_ZERO + 8'd6, CHAR_LF,
                  CHAR_PCT, CHAR_UF, CHAR_LA};
        send_string();
        // non-hex pair: both bytes come back as plain input
        str_q = '{CHAR_PCT, CHAR_UF + 8'd1, CHAR_ZERO + 8'd1};
        send_string();
        // '%' with only one byte left
        str_q = '{CHAR_PCT, CHAR_ZERO + 8'd4};
        send_string();
        str_q = '{CHAR_PCT};
        send_string();
        // replayed '%' opens a new escape
        str_q = '{CHAR_PCT, CHAR_PCT, CHAR_ZERO + 8'd4, CHAR_ZERO + 8'd1};
        send_string();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1:       limit_val = 8'd0;
                2, 7:    limit_val = 8'd255;
                3:       limit_val = 8'd1;
                4:       limit_val = 8'd2;
                5:       limit_val = 8'($urandom_range(40, 3));
                6:       limit_val = 8'd8;
                default: limit_val = MAX_BYTES_RST;
            endcase
            if (p > 0) begin
                wait_drained();
                write_limit(limit_val);
            end
            case (p % 4)
                1:       begin snd_idle_pct = 85; rcv_stall_pct = 0;  end
                2:       begin snd_idle_pct = 0;  rcv_stall_pct = 85; end
                3:       begin snd_idle_pct = 20; rcv_stall_pct = 20; end
                default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            endcase
            phase_items = 0;
            hold_fired  = 1'b0;
            if (p == 2) begin
                // long random-byte string runs the counter to the top limit
                str_q.delete();
                for (k = 0; k < 300; k++)
                    str_q.push_back(8'($urandom_range(255)));
                send_string();
            end
            while (phase_items < PHASE_ITEMS) begin
                if ((p == 0 || p == 4) && !hold_fired && phase_items >= 60) begin
                    hold_req   = 1'b1;
                    hold_fired = 1'b1;
                end
                if (p == 3 && !hold_fired && phase_items >= 100) begin
                    wait_drained();
                    hold_fired = 1'b1;
                end
                build_random_string(($urandom_range(9) == 0) ? 30 : 8);
                send_string();
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
